// File: hdl/tws_pkg.sv
// Shared types and constants for the two-wire sensor measurement master.
// No dependencies; imported by tws_cfg, tws_seq and the top level.
package tws_pkg;

	localparam int unsigned BYTE_BITS         = 8;
	localparam int unsigned CONN_RESET_CLOCKS = 9;
	localparam int unsigned CFG_INDEX_W       = 2;
	localparam int unsigned CFG_DATA_W        = 16;

	localparam logic [15:0] POLL_INTERVAL_RESET = 16'd3000;
	localparam logic [7:0]  POLL_LIMIT_RESET    = 8'd240;
	localparam logic [7:0]  RESET_CMD_RESET     = 8'd30;

	// request codes carried with each tick
	localparam logic [1:0] FUNC_TICK       = 2'd0;
	localparam logic [1:0] FUNC_MEASURE    = 2'd1;
	localparam logic [1:0] FUNC_SOFT_RESET = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_ACK  = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTERVAL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESET_COMMAND = 2'd2;

	typedef enum logic [4:0] {
		PH_IDLE, PH_CR_HI, PH_CR_LO,
		PH_ST1, PH_ST2, PH_ST3, PH_ST4, PH_ST5, PH_ST6,
		PH_WR_LO, PH_WR_HI, PH_WACK_LO, PH_WACK_HI, PH_WAIT,
		PH_RDA_HI, PH_RDA_LO, PH_ACKA_LO, PH_ACKA_HI, PH_ACKA_END,
		PH_RDB_HI, PH_RDB_LO, PH_ACKB_LO, PH_ACKB_HI
	} phase_t;

	typedef struct packed {
		logic [15:0] poll_interval;
		logic [7:0]  poll_limit;
		logic [7:0]  reset_command;
	} cfg_t;

	typedef struct packed {
		logic        clock_line;
		logic        data_release;
		logic        busy;
		logic        done;
		logic [1:0]  status;
		logic [15:0] measured_value;
	} res_t;

endpackage

// File: hdl/two_wire_sensor_measure_master_core.sv
// Top level of the two-wire sensor measurement master.
// Holds the input and result registers; uses tws_pkg, tws_cfg and tws_seq.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in      | to block  | in_valid / in_stall    | func, command_byte, data_line
//  out     | from block| out_valid / out_stall  | clock_line, data_release, busy_res,
//          |           |                        | done_res, status, measured_value
//  cfg     | to block  | cfg_we (no handshake)  | cfg_index, cfg_data
//
// One tick per cycle sustained while the output is not stalled; a tick's result is
// offered once it has passed the input register, then sequencer logic into the result register.
// The result register is refilled whenever it is empty or being taken, so a
// stalled output only holds back input once the input register is occupied.
// Asynchronous reset puts the sequencer idle and the registers at their
// defaults (poll interval 3000, poll limit 240, reset command 30).
module two_wire_sensor_measure_master_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [7:0]                      command_byte,
	input  logic                            data_line,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            clock_line,
	output logic                            data_release,
	output logic                            busy_res,
	output logic                            done_res,
	output logic [1:0]                      status,
	output logic [15:0]                     measured_value,
	// configuration
	input  logic                            cfg_we,
	input  logic [tws_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tws_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tws_pkg::*;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [7:0]  cmd_s1;
	logic        dl_s1;
	logic        out_valid_q;
	res_t        res_q;
	res_t        res_next;
	cfg_t        cfg;
	logic        adv;
	logic        in_xfer;

	// the held tick moves on when the result register can take it
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer || adv) begin
			valid_s1 <= in_xfer;
		end
	end

	// input payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1 <= func;
			cmd_s1  <= command_byte;
			dl_s1   <= data_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_next;
		end
	end

	tws_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tws_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.func         (func_s1),
		.command_byte (cmd_s1),
		.data_line    (dl_s1),
		.cfg          (cfg),
		.res          (res_next)
	);

	assign out_valid      = out_valid_q;
	assign clock_line     = res_q.clock_line;
	assign data_release   = res_q.data_release;
	assign busy_res       = res_q.busy;
	assign done_res       = res_q.done;
	assign status         = res_q.status;
	assign measured_value = res_q.measured_value;

	// a finishing tick never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with busy set");

	// idle lines: clock low, data released
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> !clock_line && data_release)
		else $error("lines not idle while not busy");

	// a timed-out measurement never carries data
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res && status == STAT_TIMEOUT |-> measured_value == 16'h0000)
		else $error("timeout with non-zero value");

	// input is held back only by a full, stalled pipe
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

// File: hdl/tws_cfg.sv
// Configuration register file: poll interval, poll limit, soft reset command.
// Depends on tws_pkg.
module tws_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tws_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tws_pkg::CFG_DATA_W-1:0]     cfg_data,
	output tws_pkg::cfg_t                      cfg
);
	import tws_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_interval <= POLL_INTERVAL_RESET;
			cfg_q.poll_limit    <= POLL_LIMIT_RESET;
			cfg_q.reset_command <= RESET_CMD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_data;
				CFG_POLL_LIMIT:    cfg_q.poll_limit    <= cfg_data[7:0];
				CFG_RESET_COMMAND: cfg_q.reset_command <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/tws_seq.sv
// Bit-level sequencer: state registers and next-state / line-level logic.
// Advances one half-bit tick per enable. Depends on tws_pkg.
module tws_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic [1:0]    func,
	input  logic [7:0]    command_byte,
	input  logic          data_line,
	input  tws_pkg::cfg_t cfg,
	output tws_pkg::res_t res
);
	import tws_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] result_q, result_d;
	logic [7:0]  poll_count_q, poll_count_d;
	logic [15:0] interval_q, interval_d;
	logic [1:0]  status_q, status_d;
	logic        soft_q, soft_d;
	logic        done;
	logic [3:0]  bc_inc;
	logic [16:0] int_inc;
	logic [8:0]  poll_inc;
	logic        clk_lvl, dat_lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			shift_q      <= '0;
			result_q     <= '0;
			poll_count_q <= '0;
			interval_q   <= '0;
			status_q     <= STAT_OK;
			soft_q       <= 1'b0;
		end else if (adv) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			result_q     <= result_d;
			poll_count_q <= poll_count_d;
			interval_q   <= interval_d;
			status_q     <= status_d;
			soft_q       <= soft_d;
		end
	end

	assign bc_inc   = bit_count_q + 4'd1;
	assign int_inc  = {1'b0, interval_q} + 17'd1;
	assign poll_inc = {1'b0, poll_count_q} + 9'd1;

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		result_d     = result_q;
		poll_count_d = poll_count_q;
		interval_d   = interval_q;
		status_d     = status_q;
		soft_d       = soft_q;
		done         = 1'b0;
		case (phase_q)
			PH_CR_HI: begin
				bit_count_d = bc_inc;
				phase_d     = PH_CR_LO;
			end
			PH_CR_LO: begin
				if (bit_count_q >= 4'(CONN_RESET_CLOCKS)) begin
					bit_count_d = '0;
					phase_d     = PH_ST1;
				end else begin
					phase_d = PH_CR_HI;
				end
			end
			PH_ST1: phase_d = PH_ST2;
			PH_ST2: phase_d = PH_ST3;
			PH_ST3: phase_d = PH_ST4;
			PH_ST4: phase_d = PH_ST5;
			PH_ST5: phase_d = PH_ST6;
			PH_ST6: begin
				bit_count_d = '0;
				phase_d     = PH_WR_LO;
			end
			PH_WR_LO: phase_d = PH_WR_HI;
			PH_WR_HI: begin
				shift_d     = {shift_q[6:0], 1'b0};
				bit_count_d = bc_inc;
				phase_d     = (bc_inc >= 4'(BYTE_BITS)) ? PH_WACK_LO : PH_WR_LO;
			end
			PH_WACK_LO: phase_d = PH_WACK_HI;
			PH_WACK_HI: begin
				if (data_line) begin
					status_d = STAT_NO_ACK;
					phase_d  = PH_IDLE;
					done     = 1'b1;
				end else if (soft_q) begin
					status_d = STAT_OK;
					phase_d  = PH_IDLE;
					done     = 1'b1;
				end else begin
					interval_d   = '0;
					poll_count_d = '0;
					phase_d      = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (int_inc < {1'b0, cfg.poll_interval}) begin
					interval_d = int_inc[15:0];
				end else begin
					interval_d = '0;
					if (!data_line) begin
						bit_count_d = '0;
						shift_d     = '0;
						phase_d     = PH_RDA_HI;
					end else if (poll_inc >= {1'b0, cfg.poll_limit}) begin
						status_d = STAT_TIMEOUT;
						phase_d  = PH_IDLE;
						done     = 1'b1;
					end else begin
						poll_count_d = poll_inc[7:0];
					end
				end
			end
			PH_RDA_HI, PH_RDB_HI: begin
				shift_d     = {shift_q[6:0], data_line};
				bit_count_d = bc_inc;
				phase_d     = (phase_q == PH_RDA_HI) ? PH_RDA_LO : PH_RDB_LO;
			end
			PH_RDA_LO: phase_d = (bit_count_q >= 4'(BYTE_BITS)) ? PH_ACKA_LO : PH_RDA_HI;
			PH_ACKA_LO: phase_d = PH_ACKA_HI;
			PH_ACKA_HI: begin
				result_d    = {shift_q, 8'h00};
				shift_d     = '0;
				bit_count_d = '0;
				phase_d     = PH_ACKA_END;
			end
			PH_ACKA_END: phase_d = PH_RDB_HI;
			PH_RDB_LO: phase_d = (bit_count_q >= 4'(BYTE_BITS)) ? PH_ACKB_LO : PH_RDB_HI;
			PH_ACKB_LO: phase_d = PH_ACKB_HI;
			PH_ACKB_HI: begin
				result_d = result_q | {8'h00, shift_q};
				status_d = STAT_OK;
				phase_d  = PH_IDLE;
				done     = 1'b1;
			end
			default: begin
				// idle, and any unused code: take a request
				phase_d = PH_IDLE;
				if (func == FUNC_MEASURE) begin
					soft_d      = 1'b0;
					shift_d     = command_byte;
					result_d    = '0;
					bit_count_d = '0;
					phase_d     = PH_ST1;
				end else if (func == FUNC_SOFT_RESET) begin
					soft_d      = 1'b1;
					shift_d     = cfg.reset_command;
					bit_count_d = '0;
					phase_d     = PH_CR_HI;
				end
			end
		endcase
	end

	// line levels for the coming half period, from the new phase
	always_comb begin
		case (phase_d)
			PH_CR_HI, PH_ST1, PH_ST5, PH_WACK_HI, PH_RDA_HI, PH_RDB_HI, PH_ACKB_HI: begin
				clk_lvl = 1'b1;
				dat_lvl = 1'b1;
			end
			PH_ST2, PH_ST4, PH_ACKA_HI: begin
				clk_lvl = 1'b1;
				dat_lvl = 1'b0;
			end
			PH_ST3, PH_ACKA_LO: begin
				clk_lvl = 1'b0;
				dat_lvl = 1'b0;
			end
			PH_WR_LO: begin
				clk_lvl = 1'b0;
				dat_lvl = shift_d[7];
			end
			PH_WR_HI: begin
				clk_lvl = 1'b1;
				dat_lvl = shift_d[7];
			end
			default: begin
				clk_lvl = 1'b0;
				dat_lvl = 1'b1;
			end
		endcase
	end

	always_comb begin
		res.clock_line     = clk_lvl;
		res.data_release   = dat_lvl;
		res.busy           = (phase_d != PH_IDLE);
		res.done           = done;
		res.status         = status_d;
		res.measured_value = result_d;
	end

endmodule

// File: bench/tb.sv
// Self-checking bench for two_wire_sensor_measure_master_core: half-bit ticks in, line levels out.
// Depends on tws_pkg for codes, phase names and the result layout, and on the core it instantiates.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tws_pkg::*;

	// selector three is not a request; the block must treat it as a plain tick
	localparam logic [1:0] FUNC_SPARE = 2'd3;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 2000;

	// one half-bit tick as offered on the input channel
	typedef struct packed {
		logic [1:0] f;
		logic [7:0] cmd;
		logic       dl;
	} tick_t;

	// sequencer state as the bench tracks it
	typedef struct {
		phase_t      ph;
		logic [3:0]  bits;
		logic [7:0]  shreg;
		logic [15:0] value;
		logic [7:0]  polls;
		logic [15:0] ticks;
		logic [1:0]  stat;
		logic        soft_rst;
	} seq_state_t;

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_stall;
	logic [1:0]             func         = FUNC_TICK;
	logic [7:0]             command_byte = 8'h00;
	logic                   data_line    = 1'b1;
	logic                   out_valid;
	logic                   out_stall    = 1'b0;
	logic                   clock_line;
	logic                   data_release;
	logic                   busy_res;
	logic                   done_res;
	logic [1:0]             status;
	logic [15:0]            measured_value;
	logic                   cfg_we       = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = CFG_POLL_INTERVAL;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	two_wire_sensor_measure_master_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.command_byte   (command_byte),
		.data_line      (data_line),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.clock_line     (clock_line),
		.data_release   (data_release),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.status         (status),
		.measured_value (measured_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// register image shared by the planner and the live sequencer copy; it only
	// changes while nothing is in flight, so one copy serves both
	cfg_t       regs;
	// plan runs ahead as the stimulus is built, live follows the accepted transfers
	seq_state_t plan;
	seq_state_t live;

	tick_t tick_backlog[$];     // ticks built but not yet offered
	res_t  awaited_outputs[$];  // predicted line levels and status, oldest first
	tick_t drive_tick;

	int queued_total = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int n_measure    = 0;
	int n_soft       = 0;
	int n_ok         = 0;
	int n_noack      = 0;
	int n_timeout    = 0;
	int send_gap     = 0;
	int send_calm    = 0;
	int hold_gap     = 0;
	int hold_calm    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic seq_state_t powered_up();
		seq_state_t s;
		s.ph       = PH_IDLE;
		s.bits     = '0;
		s.shreg    = '0;
		s.value    = '0;
		s.polls    = '0;
		s.ticks    = '0;
		s.stat     = STAT_OK;
		s.soft_rst = 1'b0;
		return s;
	endfunction

	// Advances the sequencer by one tick and returns the levels and status it
	// shows for the coming half period.
	function automatic res_t next_line_state(inout seq_state_t s, input cfg_t c,
			input logic [1:0] f, input logic [7:0] cmd, input logic dl);
		res_t r;
		logic done;
		int   n;
		done = 1'b0;
		case (s.ph)
			PH_CR_HI: begin
				s.bits = s.bits + 4'd1;
				s.ph   = PH_CR_LO;
			end
			PH_CR_LO: begin
				if (s.bits >= CONN_RESET_CLOCKS) begin
					s.bits = '0;
					s.ph   = PH_ST1;
				end else begin
					s.ph = PH_CR_HI;
				end
			end
			PH_ST1: s.ph = PH_ST2;
			PH_ST2: s.ph = PH_ST3;
			PH_ST3: s.ph = PH_ST4;
			PH_ST4: s.ph = PH_ST5;
			PH_ST5: s.ph = PH_ST6;
			PH_ST6: begin
				s.bits = '0;
				s.ph   = PH_WR_LO;
			end
			PH_WR_LO: s.ph = PH_WR_HI;
			PH_WR_HI: begin
				s.shreg = s.shreg << 1;
				s.bits  = s.bits + 4'd1;
				s.ph    = (s.bits >= BYTE_BITS) ? PH_WACK_LO : PH_WR_LO;
			end
			PH_WACK_LO: s.ph = PH_WACK_HI;
			PH_WACK_HI: begin
				if (dl) begin
					s.stat = STAT_NO_ACK;
					s.ph   = PH_IDLE;
					done   = 1'b1;
				end else if (s.soft_rst) begin
					s.stat = STAT_OK;
					s.ph   = PH_IDLE;
					done   = 1'b1;
				end else begin
					s.ticks = '0;
					s.polls = '0;
					s.ph    = PH_WAIT;
				end
			end
			PH_WAIT: begin
				n = int'(s.ticks) + 1;
				if (n < int'(c.poll_interval)) begin
					s.ticks = 16'(n);
				end else begin
					s.ticks = '0;
					if (!dl) begin
						s.bits  = '0;
						s.shreg = '0;
						s.ph    = PH_RDA_HI;
					end else begin
						n = int'(s.polls) + 1;
						if (n >= int'(c.poll_limit)) begin
							s.stat = STAT_TIMEOUT;
							s.ph   = PH_IDLE;
							done   = 1'b1;
						end else begin
							s.polls = 8'(n);
						end
					end
				end
			end
			PH_RDA_HI, PH_RDB_HI: begin
				s.shreg = {s.shreg[6:0], dl};
				s.bits  = s.bits + 4'd1;
				s.ph    = (s.ph == PH_RDA_HI) ? PH_RDA_LO : PH_RDB_LO;
			end
			PH_RDA_LO: s.ph = (s.bits >= BYTE_BITS) ? PH_ACKA_LO : PH_RDA_HI;
			PH_ACKA_LO: s.ph = PH_ACKA_HI;
			PH_ACKA_HI: begin
				s.value = {s.shreg, 8'h00};
				s.shreg = '0;
				s.bits  = '0;
				s.ph    = PH_ACKA_END;
			end
			PH_ACKA_END: s.ph = PH_RDB_HI;
			PH_RDB_LO: s.ph = (s.bits >= BYTE_BITS) ? PH_ACKB_LO : PH_RDB_HI;
			PH_ACKB_LO: s.ph = PH_ACKB_HI;
			PH_ACKB_HI: begin
				s.value = s.value | {8'h00, s.shreg};
				s.stat  = STAT_OK;
				s.ph    = PH_IDLE;
				done    = 1'b1;
			end
			default: begin
				s.ph = PH_IDLE;
				if (f == FUNC_MEASURE) begin
					s.soft_rst = 1'b0;
					s.shreg    = cmd;
					s.value    = '0;
					s.bits     = '0;
					s.ph       = PH_ST1;
				end else if (f == FUNC_SOFT_RESET) begin
					s.soft_rst = 1'b1;
					s.shreg    = c.reset_command;
					s.bits     = '0;
					s.ph       = PH_CR_HI;
				end
			end
		endcase

		case (s.ph)
			PH_CR_HI, PH_ST1, PH_ST5, PH_WACK_HI, PH_RDA_HI, PH_RDB_HI, PH_ACKB_HI:
				{r.clock_line, r.data_release} = 2'b11;
			PH_ST2, PH_ST4, PH_ACKA_HI:
				{r.clock_line, r.data_release} = 2'b10;
			PH_ST3, PH_ACKA_LO:
				{r.clock_line, r.data_release} = 2'b00;
			PH_WR_LO:
				{r.clock_line, r.data_release} = {1'b0, s.shreg[7]};
			PH_WR_HI:
				{r.clock_line, r.data_release} = {1'b1, s.shreg[7]};
			default:
				{r.clock_line, r.data_release} = 2'b01;
		endcase
		r.busy           = (s.ph != PH_IDLE);
		r.done           = done;
		r.status         = s.stat;
		r.measured_value = s.value;
		return r;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones, and now and then
	// a calm stretch with no gaps at all.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 3) begin
			calm = $urandom_range(80, 20);
			return 0;
		end
		if (r < 75)
			return 0;
		if (r < 97)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Queues one tick and moves the planning copy along with it.
	task automatic queue_tick(input logic [1:0] f, input logic [7:0] cmd, input logic dl);
		tick_t t;
		res_t  unused;
		t = '{f: f, cmd: cmd, dl: dl};
		tick_backlog.push_back(t);
		unused = next_line_state(plan, regs, f, cmd, dl);
		queued_total++;
	endtask

	// Builds a whole transaction from request to finish. The sensor side acks or
	// not as asked, and pulls data low on poll number ready_poll (never if
	// negative). noisy puts random requests on the ticks while busy.
	task automatic run_transaction(input logic [1:0] req, input logic [7:0] cmd,
			input bit acked, input int ready_poll, input bit noisy);
		logic [1:0] f;
		logic       dl;
		if (req == FUNC_MEASURE)
			n_measure++;
		else
			n_soft++;
		queue_tick(req, cmd, 1'($urandom));
		while (plan.ph != PH_IDLE) begin
			f  = noisy ? 2'($urandom) : FUNC_TICK;
			dl = 1'($urandom);
			if (plan.ph == PH_WACK_HI)
				dl = !acked;
			else if (plan.ph == PH_WAIT && int'(plan.ticks) + 1 >= int'(regs.poll_interval))
				dl = (int'(plan.polls) == ready_poll) ? 1'b0 : 1'b1;
			queue_tick(f, 8'($urandom), dl);
		end
	endtask

	// Mostly well-formed measurements with random read data, some soft resets,
	// a few idle ticks and occasional missing acks or timeouts.
	task automatic random_phase(input int target);
		int first;
		int r;
		int lim;
		first = queued_total;
		while (queued_total - first < target) begin
			r   = $urandom_range(99, 0);
			lim = (regs.poll_limit > 1) ? int'(regs.poll_limit) : 1;
			if (r < 12) begin
				repeat ($urandom_range(4, 1))
					queue_tick($urandom_range(1, 0) ? FUNC_TICK : FUNC_SPARE,
						8'($urandom), 1'($urandom));
			end else if (r < 30) begin
				run_transaction(FUNC_SOFT_RESET, 8'($urandom), $urandom_range(9, 0) != 0,
					-1, 1'($urandom));
			end else begin
				run_transaction(FUNC_MEASURE, 8'($urandom), $urandom_range(9, 0) != 0,
					($urandom_range(6, 0) == 0) ? -1 : int'($urandom_range(lim - 1, 0)),
					$urandom_range(3, 0) != 0);
			end
		end
	endtask

	// Writes all three registers back to back; the upper byte of the 8-bit
	// registers carries junk that must be dropped.
	task automatic set_regs(input logic [15:0] interval, input logic [7:0] limit,
			input logic [7:0] rcmd);
		@(posedge clk);
		cfg_we             <= 1'b1;
		cfg_index          <= CFG_POLL_INTERVAL;
		cfg_data           <= interval;
		regs.poll_interval  = interval;
		@(posedge clk);
		cfg_index          <= CFG_POLL_LIMIT;
		cfg_data           <= {8'($urandom), limit};
		regs.poll_limit     = limit;
		@(posedge clk);
		cfg_index          <= CFG_RESET_COMMAND;
		cfg_data           <= {8'($urandom), rcmd};
		regs.reset_command  = rcmd;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued tick has come back as a result, then lets the
	// pipeline run dry.
	task automatic settle();
		while (results_seen < queued_total)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		res_t want;
		results_seen++;
		if (done_res) begin
			if (status == STAT_OK)
				n_ok++;
			else if (status == STAT_NO_ACK)
				n_noack++;
			else
				n_timeout++;
		end
		if (awaited_outputs.size() == 0) begin
			$error("result transfer with nothing expected");
			mismatches++;
		end else begin
			want = awaited_outputs.pop_front();
			check_field("clock_line", want.clock_line, clock_line);
			check_field("data_release", want.data_release, data_release);
			check_field("busy_res", want.busy, busy_res);
			check_field("done_res", want.done, done_res);
			check_field("status", want.status, status);
			check_field("measured_value", want.measured_value, measured_value);
		end
	endtask

	// Input driver: a tick is predicted at the edge its transfer completes, so
	// the live copy follows exactly what the block took.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap  = 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				awaited_outputs.push_back(next_line_state(live, regs, func, command_byte,
					data_line));
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (tick_backlog.size() != 0) begin
				drive_tick    = tick_backlog.pop_front();
				func         <= drive_tick.f;
				command_byte <= drive_tick.cmd;
				data_line    <= drive_tick.dl;
				in_valid     <= 1'b1;
				send_gap      = pick_gap(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_gap   = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (hold_gap > 0) begin
				hold_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				hold_gap   = pick_gap(hold_calm);
			end
		end
	end

	// Watchdog: ends the run once no transfer has happened on either channel
	// for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int k;
		regs = '{poll_interval: POLL_INTERVAL_RESET, poll_limit: POLL_LIMIT_RESET,
			reset_command: RESET_CMD_RESET};
		plan = powered_up();
		live = powered_up();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset register values, where nothing waits on the
		// poll interval: spare selector and plain ticks while idle, soft reset
		// with ack and requests arriving while busy, a soft reset without ack,
		// then a measurement with no ack.
		queue_tick(FUNC_SPARE, 8'hFF, 1'b1);
		queue_tick(FUNC_TICK, 8'h00, 1'b0);
		run_transaction(FUNC_SOFT_RESET, 8'hA5, 1'b1, -1, 1'b1);
		run_transaction(FUNC_SOFT_RESET, 8'h00, 1'b0, -1, 1'b0);
		run_transaction(FUNC_MEASURE, 8'h00, 1'b0, -1, 1'b0);
		queue_tick(FUNC_TICK, 8'h5A, 1'b1);
		settle();

		// Zero interval and zero limit: poll every tick, time out on first miss.
		// A full measurement with all-ones command, a soft reset without ack
		// (the value must survive it), then a timeout.
		set_regs(16'd0, 8'd0, 8'hFF);
		run_transaction(FUNC_MEASURE, 8'hFF, 1'b1, 0, 1'b1);
		run_transaction(FUNC_SOFT_RESET, 8'h00, 1'b0, -1, 1'b1);
		run_transaction(FUNC_MEASURE, 8'h7E, 1'b1, -1, 1'b1);
		settle();

		// Widest poll limit, sensor ready after many polls.
		set_regs(16'd1, 8'd255, 8'h00);
		run_transaction(FUNC_MEASURE, 8'hC0, 1'b1, 60, 1'b1);
		settle();

		// Random part over several register settings with short poll times.
		for (k = 0; k < 3; k++) begin
			set_regs(($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(6, 1)),
				($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom_range(8, 1)),
				8'($urandom));
			random_phase(40);
			settle();
		end
		repeat (8) @(posedge clk);

		if (awaited_outputs.size() != 0) begin
			$error("%0d expected results never arrived", awaited_outputs.size());
			mismatches++;
		end
		$display("Ran %0d ticks through %0d measurements and %0d soft resets, %0d results checked",
			queued_total, n_measure, n_soft, results_seen);
		$display("Finished: %0d ok, %0d without ack, %0d timed out; %0d mismatches",
			n_ok, n_noack, n_timeout, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
